/* rtl/core/tmwd_pkg.sv */
// Package for the task-monitored watchdog core.
// Holds the input kind codes, configuration register indexes and field widths.
// No dependencies.
package tmwd_pkg;

  localparam int unsigned KIND_W     = 3;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned ID_W       = 2;
  localparam int unsigned MASK_W     = 4;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LIMIT_REGS = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 3'd0,
    KIND_CHECKIN = 3'd1,
    KIND_CHECK   = 3'd2,
    KIND_FEED    = 3'd3,
    KIND_START   = 3'd4
  } kind_t;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  localparam cfg_addr_t CFG_WD_TIMEOUT  = 3'd0;
  localparam cfg_addr_t CFG_TASK_COUNT  = 3'd1;
  localparam cfg_addr_t CFG_TASK0_LIMIT = 3'd2;
  localparam cfg_addr_t CFG_TASK1_LIMIT = 3'd3;
  localparam cfg_addr_t CFG_TASK2_LIMIT = 3'd4;
  localparam cfg_addr_t CFG_TASK3_LIMIT = 3'd5;

  localparam logic [MS_W-1:0] WD_TIMEOUT_RESET = 16'd100;

endpackage

/* rtl/core/task_monitored_watchdog_core.sv */
// Top level of the task-monitored watchdog core: input register, event logic,
// result register and the configuration registers.
// Depends on tmwd_pkg.

// Takes one event beat per clock while the result side is not stalled (tick,
// checkin, check, feed, start or reserved) and presents exactly one status beat
// for each, through the input register and then the result register. Sustained
// rate is one beat per cycle when not stalled: all state (time base, task
// stamps, alive flags, countdown) updates in the single cycle in which a beat
// moves from the input register to the result register. A stalled result
// holds the input register; a new beat is taken while the result register is
// emptied in the same cycle. Write configuration only while no beat is in flight.
module task_monitored_watchdog_core #(
  parameter int unsigned TASK_SLOTS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tmwd_pkg::CFG_ADDR_W-1:0]     cfg_index,
  input  logic [tmwd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tmwd_pkg::KIND_W-1:0]         in_kind,
  input  logic [tmwd_pkg::MS_W-1:0]           in_elapsed_ms,
  input  logic [tmwd_pkg::ID_W-1:0]           in_task_id,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_all_ok,
  output logic [tmwd_pkg::MASK_W-1:0]         out_alive_mask,
  output logic                                out_fired,
  output logic [tmwd_pkg::MS_W-1:0]           out_count_left
);
  import tmwd_pkg::*;

  // configuration
  logic [MS_W-1:0]  wd_timeout_r;
  logic [CNT_W-1:0] task_count_r;
  logic [MS_W-1:0]  task_limit_r [LIMIT_REGS];

  // input register
  logic             in_v_r;
  kind_t            in_kind_r;
  logic [MS_W-1:0]  in_elapsed_r;
  logic [ID_W-1:0]  in_task_id_r;

  // state
  logic [TIME_W-1:0]     time_r, time_nxt;
  logic [TIME_W-1:0]     ckin_r [TASK_SLOTS];
  logic [TIME_W-1:0]     ckin_nxt [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] alive_r, alive_nxt;
  logic [MS_W-1:0]       count_r, count_nxt;
  logic                  en_r, en_nxt;
  logic                  fired_r, fired_nxt;
  logic                  ok_nxt;

  logic [CNT_W-1:0]      n_act;
  logic [TASK_SLOTS-1:0] late;
  logic                  adv;

  assign adv      = in_v_r && (!out_valid || out_ready);
  assign in_ready = !in_v_r || adv;

  // clamp registered task count to the number of slots
  assign n_act = (task_count_r > CNT_W'(TASK_SLOTS)) ? CNT_W'(TASK_SLOTS) : task_count_r;

  always_comb begin
    logic [TIME_W-1:0] age;
    late = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      age     = time_r - ckin_r[i];
      late[i] = age > {{(TIME_W-MS_W){1'b0}}, task_limit_r[i]};
    end
  end

  always_comb begin
    time_nxt  = time_r;
    ckin_nxt  = ckin_r;
    alive_nxt = alive_r;
    count_nxt = count_r;
    en_nxt    = en_r;
    fired_nxt = fired_r;
    ok_nxt    = 1'b0;
    case (in_kind_r)
      KIND_TICK: begin
        time_nxt = time_r + {{(TIME_W-MS_W){1'b0}}, in_elapsed_r};
        if (en_r && !fired_r) begin
          if (count_r <= in_elapsed_r) begin
            count_nxt = '0;
            fired_nxt = 1'b1;
          end else begin
            count_nxt = count_r - in_elapsed_r;
          end
        end
      end
      KIND_CHECKIN: begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (in_task_id_r == ID_W'(i) && CNT_W'(i) < n_act) begin
            ckin_nxt[i]  = time_r;
            alive_nxt[i] = 1'b1;
          end
        end
      end
      KIND_CHECK: begin
        ok_nxt = 1'b1;
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (CNT_W'(i) < n_act && late[i]) begin
            alive_nxt[i] = 1'b0;
            ok_nxt       = 1'b0;
          end
        end
        if (ok_nxt && en_r) count_nxt = wd_timeout_r;
      end
      KIND_FEED: begin
        if (en_r) count_nxt = wd_timeout_r;
      end
      KIND_START: begin
        en_nxt    = 1'b1;
        fired_nxt = 1'b0;
        count_nxt = wd_timeout_r;
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (CNT_W'(i) < n_act) begin
            ckin_nxt[i]  = time_r;
            alive_nxt[i] = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_timeout_r <= WD_TIMEOUT_RESET;
      task_count_r <= '0;
      for (int i = 0; i < LIMIT_REGS; i++) task_limit_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WD_TIMEOUT:  wd_timeout_r    <= cfg_wdata;
        CFG_TASK_COUNT:  task_count_r    <= cfg_wdata[CNT_W-1:0];
        CFG_TASK0_LIMIT: task_limit_r[0] <= cfg_wdata;
        CFG_TASK1_LIMIT: task_limit_r[1] <= cfg_wdata;
        CFG_TASK2_LIMIT: task_limit_r[2] <= cfg_wdata;
        CFG_TASK3_LIMIT: task_limit_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_kind_r    <= kind_t'(in_kind);
      in_elapsed_r <= in_elapsed_ms;
      in_task_id_r <= in_task_id;
    end
  end

  // state advances once per beat moved into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r  <= '0;
      alive_r <= '0;
      count_r <= '0;
      en_r    <= 1'b0;
      fired_r <= 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) ckin_r[i] <= '0;
    end else if (adv) begin
      time_r  <= time_nxt;
      alive_r <= alive_nxt;
      count_r <= count_nxt;
      en_r    <= en_nxt;
      fired_r <= fired_nxt;
      for (int i = 0; i < TASK_SLOTS; i++) ckin_r[i] <= ckin_nxt[i];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_all_ok     <= ok_nxt;
      out_alive_mask <= MASK_W'(alive_nxt);
      out_fired      <= fired_nxt;
      out_count_left <= count_nxt;
    end
  end

  // fired stays set until a start beat passes
  assert property (@(posedge clk) disable iff (!rst_n)
    fired_r && !(adv && in_kind_r == KIND_START) |=> fired_r)
    else $error("fired flag cleared without start");

  // the watchdog can only have fired once enabled
  assert property (@(posedge clk) disable iff (!rst_n)
    fired_r |-> en_r)
    else $error("fired while watchdog disabled");

  // each result beat reports the state left by its event
  assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid && out_fired == fired_r && out_count_left == count_r)
    else $error("result does not match watchdog state");

endmodule

/* dv/task_monitored_watchdog_core_test.sv */
// Self-checking testbench for task_monitored_watchdog_core: directed and random event beats.
// Holds a scoreboard class with its own watchdog predictor; depends on tmwd_pkg and the core RTL.
`timescale 1ns / 100ps

module task_monitored_watchdog_core_test;
  import tmwd_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned PHASE_BEATS     = 140;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned HOLD_CYCLES     = 80;
  localparam int unsigned HOLD_AT_RESULT  = 400;
  localparam logic [KIND_W-1:0] KIND_RSVD_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD_LAST  = 3'd7;

  typedef struct packed {
    logic              all_ok;
    logic [MASK_W-1:0] alive_mask;
    logic              fired;
    logic [MS_W-1:0]   count_left;
  } wd_status_t;

  class watchdog_scoreboard;
    logic [MS_W-1:0]   reload_ms;
    logic [CNT_W-1:0]  task_regs;
    logic [MS_W-1:0]   limit_ms [LIMIT_REGS];
    logic [TIME_W-1:0] time_base;
    logic [TIME_W-1:0] stamp [LIMIT_REGS];
    logic [MASK_W-1:0] alive;
    logic [MS_W-1:0]   countdown;
    logic              armed;
    logic              tripped;
    wd_status_t        status_q[$];
    int unsigned       mismatches;
    int unsigned       checked;

    function new();
      reload_ms  = WD_TIMEOUT_RESET;
      task_regs  = '0;
      time_base  = '0;
      alive      = '0;
      countdown  = '0;
      armed      = 1'b0;
      tripped    = 1'b0;
      mismatches = 0;
      checked    = 0;
      for (int i = 0; i < LIMIT_REGS; i++) begin
        limit_ms[i] = '0;
        stamp[i]    = '0;
      end
    endfunction

    function void write_reg(cfg_addr_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_WD_TIMEOUT:  reload_ms = data;
        CFG_TASK_COUNT:  task_regs = data[CNT_W-1:0];
        CFG_TASK0_LIMIT: limit_ms[0] = data;
        CFG_TASK1_LIMIT: limit_ms[1] = data;
        CFG_TASK2_LIMIT: limit_ms[2] = data;
        CFG_TASK3_LIMIT: limit_ms[3] = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return status_q.size();
    endfunction

    function void note_input(logic [KIND_W-1:0] kind, logic [MS_W-1:0] elapsed,
                             logic [ID_W-1:0] id);
      int unsigned active;
      logic [TIME_W-1:0] age;
      wd_status_t s;
      active = (task_regs > LIMIT_REGS) ? LIMIT_REGS : task_regs;
      s.all_ok = 1'b0;
      case (kind)
        KIND_TICK: begin
          time_base = time_base + TIME_W'(elapsed);
          if (armed && !tripped) begin
            if (countdown <= elapsed) begin
              countdown = '0;
              tripped   = 1'b1;
            end else begin
              countdown = countdown - elapsed;
            end
          end
        end
        KIND_CHECKIN: begin
          if (int'(id) < active) begin
            stamp[id] = time_base;
            alive[id] = 1'b1;
          end
        end
        KIND_CHECK: begin
          s.all_ok = 1'b1;
          for (int i = 0; i < active; i++) begin
            age = time_base - stamp[i];
            if (age > TIME_W'(limit_ms[i])) begin
              alive[i] = 1'b0;
              s.all_ok = 1'b0;
            end
          end
          if (s.all_ok && armed) countdown = reload_ms;
        end
        KIND_FEED: begin
          if (armed) countdown = reload_ms;
        end
        KIND_START: begin
          armed     = 1'b1;
          tripped   = 1'b0;
          countdown = reload_ms;
          for (int i = 0; i < active; i++) begin
            stamp[i] = time_base;
            alive[i] = 1'b1;
          end
        end
        default: ;
      endcase
      s.alive_mask = alive;
      s.fired      = tripped;
      s.count_left = countdown;
      status_q.push_back(s);
    endfunction

    function void check_result(wd_status_t got);
      wd_status_t want;
      checked++;
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] status beat with nothing outstanding: ok=%0b mask=%h fired=%0b cnt=%0d",
                   $realtime, got.all_ok, got.alive_mask, got.fired, got.count_left);
        return;
      end
      want = status_q.pop_front();
      if (got.all_ok !== want.all_ok || got.alive_mask !== want.alive_mask ||
          got.fired !== want.fired || got.count_left !== want.count_left) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] status differs: exp ok=%0b mask=%h fired=%0b cnt=%0d, got ok=%0b mask=%h fired=%0b cnt=%0d",
                   $realtime, want.all_ok, want.alive_mask, want.fired, want.count_left,
                   got.all_ok, got.alive_mask, got.fired, got.count_left);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [KIND_W-1:0]     in_kind = '0;
  logic [MS_W-1:0]       in_elapsed_ms = '0;
  logic [ID_W-1:0]       in_task_id = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_all_ok;
  logic [MASK_W-1:0]     out_alive_mask;
  logic                  out_fired;
  logic [MS_W-1:0]       out_count_left;

  watchdog_scoreboard sb;
  bit          quiet = 1'b0;
  int unsigned cfg_sets = 0;
  int unsigned cycle_count = 0;

  task_monitored_watchdog_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_elapsed_ms (in_elapsed_ms),
    .in_task_id    (in_task_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_all_ok    (out_all_ok),
    .out_alive_mask(out_alive_mask),
    .out_fired     (out_fired),
    .out_count_left(out_count_left)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one event beat; valid may first drop for a random gap unless quiet is set.
  task send_beat(input logic [KIND_W-1:0] kind, input logic [MS_W-1:0] elapsed,
                 input logic [ID_W-1:0] id);
    if (!quiet && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_elapsed_ms <= elapsed;
    in_task_id    <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(kind, elapsed, id);
  endtask

  // Drop valid and wait until every outstanding status beat has come back.
  task settle_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_cfg(input cfg_addr_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task program_regs(input logic [MS_W-1:0] timeout, input logic [CNT_W-1:0] tasks,
                    input logic [MS_W-1:0] l0, input logic [MS_W-1:0] l1,
                    input logic [MS_W-1:0] l2, input logic [MS_W-1:0] l3);
    write_cfg(CFG_WD_TIMEOUT, timeout);
    write_cfg(CFG_TASK_COUNT, CFG_DATA_W'(tasks));
    write_cfg(CFG_TASK0_LIMIT, l0);
    write_cfg(CFG_TASK1_LIMIT, l1);
    write_cfg(CFG_TASK2_LIMIT, l2);
    write_cfg(CFG_TASK3_LIMIT, l3);
    cfg_sets++;
  endtask

  // Mostly modest spans so ticks, check-ins and checks interleave before firing.
  function automatic logic [MS_W-1:0] pick_span(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return MS_W'($urandom_range(lo, hi));
    if (r < 90) return MS_W'($urandom_range(hi, hi * 8));
    return MS_W'($urandom_range(0, 65535));
  endfunction

  task random_beat();
    int unsigned r;
    logic [KIND_W-1:0] kind;
    logic [MS_W-1:0] elapsed;
    r = $urandom_range(0, 99);
    if (r < 35)      kind = KIND_TICK;
    else if (r < 62) kind = KIND_CHECKIN;
    else if (r < 82) kind = KIND_CHECK;
    else if (r < 91) kind = KIND_FEED;
    else if (r < 96) kind = KIND_START;
    else             kind = KIND_W'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST));
    r = $urandom_range(0, 99);
    if (r < 75)      elapsed = MS_W'($urandom_range(0, 30));
    else if (r < 95) elapsed = MS_W'($urandom_range(0, 500));
    else             elapsed = MS_W'($urandom_range(0, 65535));
    send_beat(kind, elapsed, ID_W'($urandom_range(0, 3)));
  endtask

  // Result side: check, then decide ready; a long hold-off lets the core back up.
  initial begin : result_side
    int unsigned hold_left;
    bit          hold_done;
    wd_status_t  got;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.all_ok     = out_all_ok;
        got.alive_mask = out_alive_mask;
        got.fired      = out_fired;
        got.count_left = out_count_left;
        sb.check_result(got);
      end
      if (!hold_done && sb.checked >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  initial begin : watchdog_limit
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d status beats outstanding", cycle_count, sb.pending());
    $display("task_monitored_watchdog_core: mismatch");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no tasks, disabled watchdog.
    send_beat(KIND_TICK, 16'hFFFF, 2'd0);
    send_beat(KIND_CHECK, 16'd0, 2'd0);
    send_beat(KIND_FEED, 16'd0, 2'd0);
    for (int k = KIND_RSVD_FIRST; k <= KIND_RSVD_LAST; k++)
      send_beat(KIND_W'(k), 16'hFFFF, 2'd3);
    send_beat(KIND_START, 16'd0, 2'd0);
    send_beat(KIND_TICK, 16'd40, 2'd0);
    send_beat(KIND_CHECKIN, 16'd0, 2'd0);
    send_beat(KIND_CHECK, 16'd0, 2'd0);
    send_beat(KIND_TICK, 16'd99, 2'd0);
    send_beat(KIND_TICK, 16'd1, 2'd0);
    send_beat(KIND_FEED, 16'd0, 2'd0);
    send_beat(KIND_TICK, 16'd5, 2'd0);
    settle_idle();

    // Oversized task count, zero reload, extreme limits.
    program_regs(16'd0, 3'd7, 16'd0, 16'hFFFF, 16'd10, 16'd1);
    send_beat(KIND_START, 16'd0, 2'd0);
    send_beat(KIND_TICK, 16'd0, 2'd0);
    send_beat(KIND_CHECKIN, 16'd0, 2'd3);
    send_beat(KIND_TICK, 16'd5, 2'd0);
    send_beat(KIND_CHECK, 16'd0, 2'd0);
    send_beat(KIND_CHECKIN, 16'd0, 2'd0);
    send_beat(KIND_CHECK, 16'd0, 2'd0);
    settle_idle();

    // Two tasks: upper slots keep their stale stamps and flags.
    program_regs(16'd300, 3'd2, 16'd50, 16'd50, 16'd50, 16'd50);
    send_beat(KIND_START, 16'd0, 2'd0);
    send_beat(KIND_CHECKIN, 16'd0, 2'd3);
    send_beat(KIND_TICK, 16'hFFFF, 2'd0);
    send_beat(KIND_CHECK, 16'd0, 2'd0);
    settle_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: program_regs(16'hFFFF, 3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: program_regs(16'd0, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        default: program_regs(pick_span(50, 600), CNT_W'($urandom_range(0, 7)),
                              pick_span(10, 120), pick_span(10, 120),
                              pick_span(10, 120), pick_span(10, 120));
      endcase
      send_beat(KIND_START, 16'd0, 2'd0);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        quiet = (p == 3) && (n < 90);
        random_beat();
      end
      quiet = 1'b0;
      settle_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d status beats across %0d register settings in %0d cycles",
             sb.checked, cfg_sets, cycle_count);
    $display("covered ticks, check-ins, checks, feeds, starts, reserved kinds and a long output stall");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("task_monitored_watchdog_core: match");
    end else begin
      $display("%0d mismatches, %0d status beats outstanding", sb.mismatches, sb.pending());
      $display("task_monitored_watchdog_core: mismatch");
    end
    $finish;
  end

endmodule
